// ----- sv/gpa_pkg.sv -----
package gpa_pkg;

  localparam int MAX_DEGREE = 16;
  localparam int OPND_W     = MAX_DEGREE + 1;
  localparam int RESULT_W   = 2 * MAX_DEGREE + 1;
  localparam int REM_W      = MAX_DEGREE;
  localparam int NUM_CELLS  = OPND_W;
  localparam int LATENCY    = NUM_CELLS + 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_DIV = 2'd2
  } op_t;

  // One beat as it moves along the cell row.
  typedef struct packed {
    logic                valid;
    logic [1:0]          op;
    logic [OPND_W-1:0]   a;     // dividend or multiplier, consumed from the top bit
    logic [OPND_W-1:0]   b;     // divisor or multiplicand
    logic [OPND_W-1:0]   bt;    // one-hot mark of the top set bit of b
    logic [RESULT_W-1:0] acc;   // sum, product, or partial remainder in the low bits
    logic [OPND_W-1:0]   q;     // quotient bits, shifted in one per cell
  } cell_t;

  // One-hot mask of the highest set bit; zero for a zero word.
  function automatic logic [OPND_W-1:0] top_one(input logic [OPND_W-1:0] v);
    logic [OPND_W-1:0] t;
    logic              seen;
    t    = '0;
    seen = 1'b0;
    for (int k = OPND_W - 1; k >= 0; k--) begin
      t[k] = v[k] & ~seen;
      seen = seen | v[k];
    end
    return t;
  endfunction

endpackage

// ----- sv/gf2_polynomial_alu.sv -----
// GF(2) polynomial ALU: add (XOR), carry-less multiply, long division; op 3 gives zero.
// Bit k of an operand is the coefficient of x^k; operands go up to degree 16.
//
// Command channel: drive op, operand_a, operand_b with start high; a beat is
// taken at each rising edge where start is high and busy is low. busy is high
// only while rst is asserted, so a new beat can enter every cycle.
//
// Result channel: result, remainder and divide_by_zero are valid for exactly
// one cycle while done is high. Beats leave in the order they entered, one
// per cycle at most. The receiver cannot stall the block; a result not
// sampled during its done cycle is gone.
//
// The datapath is a row of 17 identical cells, one per operand bit, each
// taking one dividend/multiplier bit per cycle, with an input stage in front
// and an output register behind; it takes one beat per cycle.
//
// Synchronous reset empties the cell row; no done pulse follows until new
// beats are taken. A zero divisor gives zero results with divide_by_zero set.
module gf2_polynomial_alu (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    op,
  input  logic [gpa_pkg::OPND_W-1:0]    operand_a,
  input  logic [gpa_pkg::OPND_W-1:0]    operand_b,
  output logic                          done,
  output logic [gpa_pkg::RESULT_W-1:0]  result,
  output logic [gpa_pkg::REM_W-1:0]     remainder,
  output logic                          divide_by_zero
);
  import gpa_pkg::*;

  cell_t               pipe [NUM_CELLS+1];
  cell_t               prep;
  cell_t               prep_next;
  cell_t               last;
  logic [RESULT_W-1:0] result_next;
  logic [REM_W-1:0]    remainder_next;
  logic                dz_next;

  assign busy = rst;

  always_comb begin
    // busy follows rst, so no beat enters while in reset
    prep_next.valid = start & ~busy;
    prep_next.op    = op;
    prep_next.a     = operand_a;
    prep_next.b     = operand_b;
    prep_next.bt    = top_one(operand_b);
    prep_next.q     = '0;
    // seed the accumulator: the sum is complete at entry
    prep_next.acc   = (op == OP_ADD)
                    ? {{(RESULT_W-OPND_W){1'b0}}, operand_a ^ operand_b}
                    : '0;
  end

  always_ff @(posedge clk) begin
    prep <= prep_next;
  end

  assign pipe[0] = prep;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    gpa_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .cin  (pipe[i]),
      .cout (pipe[i+1])
    );
  end

  assign last = pipe[NUM_CELLS];

  always_comb begin
    result_next    = '0;
    remainder_next = '0;
    dz_next        = 1'b0;
    case (last.op)
      OP_ADD, OP_MUL: begin
        result_next = last.acc;
      end
      OP_DIV: begin
        if (last.b == '0) begin
          dz_next = 1'b1;
        end else begin
          result_next    = {{(RESULT_W-OPND_W){1'b0}}, last.q};
          remainder_next = last.acc[REM_W-1:0];
        end
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
    result         <= result_next;
    remainder      <= remainder_next;
    divide_by_zero <= dz_next;
  end

endmodule

// ----- sv/gpa_cell.sv -----
module gpa_cell (
  input  logic           clk,
  input  logic           rst,
  input  gpa_pkg::cell_t cin,
  output gpa_pkg::cell_t cout
);
  import gpa_pkg::*;

  logic                abit;
  logic [OPND_W-1:0]   r_sh;
  logic                hit;
  cell_t               nxt;

  assign abit = cin.a[OPND_W-1];
  assign r_sh = {cin.acc[OPND_W-2:0], abit};
  assign hit  = |(r_sh & cin.bt);

  always_comb begin
    nxt       = cin;
    // drop the beat while in reset
    nxt.valid = cin.valid & ~rst;
    nxt.a     = {cin.a[OPND_W-2:0], 1'b0};
    case (cin.op)
      OP_MUL: begin
        // Horner step: shift the product, fold in b when this multiplier bit is set
        nxt.acc = {cin.acc[RESULT_W-2:0], 1'b0}
                ^ {{(RESULT_W-OPND_W){1'b0}}, cin.b & {OPND_W{abit}}};
      end
      OP_DIV: begin
        // bring down the next dividend bit, subtract b when the degree reaches deg(b)
        nxt.acc = {{(RESULT_W-OPND_W){1'b0}}, (hit ? (r_sh ^ cin.b) : r_sh)};
        nxt.q   = {cin.q[OPND_W-2:0], hit};
      end
      default: begin
        nxt.acc = cin.acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cout <= nxt;
  end

endmodule

// ----- sv/gpa_checker.sv -----
module gpa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [gpa_pkg::RESULT_W-1:0]  result,
  input logic [gpa_pkg::REM_W-1:0]     remainder,
  input logic                          divide_by_zero
);
  import gpa_pkg::*;

  // every taken beat comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("beat taken without a done pulse after the pipeline latency");

  // no done pulse without a beat taken the pipeline latency earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("done pulse with no matching beat");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done pulse right after reset");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && divide_by_zero) |-> (result == '0 && remainder == '0))
    else $error("divide by zero with nonzero results");

endmodule

bind gf2_polynomial_alu gpa_checker u_gpa_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .result         (result),
  .remainder      (remainder),
  .divide_by_zero (divide_by_zero)
);

// ----- tb/tb_gf2_polynomial_alu.sv -----
module tb_gf2_polynomial_alu;
  import gpa_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [OPND_W-1:0] ALL_ONES = {OPND_W{1'b1}};
  localparam int RANDOM_BEATS = 475;

  typedef struct {
    logic [1:0]          op;
    logic [OPND_W-1:0]   a;
    logic [OPND_W-1:0]   b;
    logic [RESULT_W-1:0] result;
    logic [REM_W-1:0]    remainder;
    logic                dz;
  } poly_answer_t;

  class poly_answer_book;
    poly_answer_t pending_answers[$];
    int n_checked;
    int n_mismatches;
    int n_by_op[4];
    int n_div_zero;

    function logic [RESULT_W-1:0] carryless_product(logic [OPND_W-1:0] a,
                                                    logic [OPND_W-1:0] b);
      logic [RESULT_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < OPND_W; k++)
        if (a[k]) acc ^= RESULT_W'(b) << k;
      return acc;
    endfunction

    function void long_divide(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b,
                              output logic [OPND_W-1:0] q, output logic [OPND_W-1:0] r);
      int db;
      db = 0;
      for (int k = 0; k < OPND_W; k++)
        if (b[k]) db = k;
      q = '0;
      r = a;
      for (int k = OPND_W - 1; k >= db; k--) begin
        if (r[k]) begin
          r ^= b << (k - db);
          q[k - db] = 1'b1;
        end
      end
    endfunction

    function poly_answer_t predict_poly_op(logic [1:0] op, logic [OPND_W-1:0] a,
                                           logic [OPND_W-1:0] b);
      poly_answer_t ans;
      logic [OPND_W-1:0] q, r;
      ans.op = op;
      ans.a = a;
      ans.b = b;
      ans.result = '0;
      ans.remainder = '0;
      ans.dz = 1'b0;
      case (op)
        OP_ADD: ans.result = RESULT_W'(a ^ b);
        OP_MUL: ans.result = carryless_product(a, b);
        OP_DIV: begin
          if (b == '0) begin
            ans.dz = 1'b1;
          end else begin
            long_divide(a, b, q, r);
            ans.result = RESULT_W'(q);
            ans.remainder = r[REM_W-1:0];
          end
        end
        default: ;
      endcase
      return ans;
    endfunction

    function void note_command(logic [1:0] op, logic [OPND_W-1:0] a,
                               logic [OPND_W-1:0] b);
      poly_answer_t ans;
      ans = predict_poly_op(op, a, b);
      pending_answers.push_back(ans);
      n_by_op[op]++;
      if (ans.dz) n_div_zero++;
    endfunction

    function void check_result(logic [RESULT_W-1:0] result, logic [REM_W-1:0] remainder,
                               logic dz);
      poly_answer_t ans;
      if (pending_answers.size() == 0) begin
        n_mismatches++;
        if (n_mismatches <= 10)
          $display("ERROR: result with nothing pending: result=%h rem=%h dz=%b",
                   result, remainder, dz);
        return;
      end
      ans = pending_answers.pop_front();
      n_checked++;
      if (result !== ans.result || remainder !== ans.remainder || dz !== ans.dz) begin
        n_mismatches++;
        if (n_mismatches <= 10)
          $display("ERROR: op=%0d a=%h b=%h expected result=%h rem=%h dz=%b, got result=%h rem=%h dz=%b",
                   ans.op, ans.a, ans.b, ans.result, ans.remainder, ans.dz,
                   result, remainder, dz);
      end
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [1:0]          op;
  logic [OPND_W-1:0]   operand_a;
  logic [OPND_W-1:0]   operand_b;
  logic                done;
  logic [RESULT_W-1:0] result;
  logic [REM_W-1:0]    remainder;
  logic                divide_by_zero;

  poly_answer_book book = new();

  gf2_polynomial_alu uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .operand_a      (operand_a),
    .operand_b      (operand_b),
    .done           (done),
    .result         (result),
    .remainder      (remainder),
    .divide_by_zero (divide_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check any outgoing result before noting a beat taken on the same edge.
  always @(posedge clk) begin
    if (done) book.check_result(result, remainder, divide_by_zero);
    if (!rst && start && !busy) book.note_command(op, operand_a, operand_b);
  end

  task automatic send_beat(input logic [1:0] beat_op, input logic [OPND_W-1:0] a,
                           input logic [OPND_W-1:0] b, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    op <= beat_op;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  // Mix of shapes: zero, single term, all ones, random degree, full random.
  function automatic logic [OPND_W-1:0] random_poly();
    int shape;
    int deg;
    logic [OPND_W-1:0] v;
    shape = $urandom_range(0, 9);
    case (shape)
      0: v = '0;
      1: v = OPND_W'(1) << $urandom_range(0, OPND_W - 1);
      2: v = ALL_ONES;
      3, 4, 5: begin
        deg = $urandom_range(0, OPND_W - 1);
        v = OPND_W'($urandom) & ((OPND_W'(1) << deg) - 1'b1);
        v[deg] = 1'b1;
      end
      default: v = OPND_W'($urandom_range(0, 2**OPND_W - 1));
    endcase
    return v;
  endfunction

  function automatic logic [1:0] random_op();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return OP_UNUSED;
    else if (r < 8) return OP_DIV;
    else if (r < 14) return OP_MUL;
    else return OP_ADD;
  endfunction

  initial begin
    #(8 * 80000);
    $display("Timeout: %0d results still pending", book.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int gap_max;
    rst = 1'b1;
    start = 1'b0;
    op = OP_ADD;
    operand_a = '0;
    operand_b = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes and each special case.
    send_beat(OP_ADD, '0, '0, 0);
    send_beat(OP_ADD, ALL_ONES, '0, 0);
    send_beat(OP_ADD, ALL_ONES, ALL_ONES, 0);
    send_beat(OP_ADD, 17'h0AAAA, 17'h15555, 1);
    send_beat(OP_MUL, '0, ALL_ONES, 0);
    send_beat(OP_MUL, ALL_ONES, ALL_ONES, 0);
    send_beat(OP_MUL, 17'h10000, 17'h10000, 0);
    send_beat(OP_MUL, 17'h00001, 17'h15555, 2);
    send_beat(OP_MUL, 17'h00003, 17'h00003, 0);
    send_beat(OP_DIV, 17'h12345, '0, 0);
    send_beat(OP_DIV, '0, '0, 0);
    send_beat(OP_DIV, '0, 17'h00013, 0);
    send_beat(OP_DIV, 17'h00005, 17'h00100, 0);
    send_beat(OP_DIV, ALL_ONES, 17'h00001, 0);
    send_beat(OP_DIV, ALL_ONES, ALL_ONES, 0);
    send_beat(OP_DIV, ALL_ONES, 17'h10000, 3);
    send_beat(OP_DIV, 17'h10000, 17'h00003, 0);
    send_beat(OP_DIV, 17'h1ABCD, 17'h0011B, 0);
    send_beat(OP_DIV, 17'h0FFFF, 17'h0FFFF, 0);
    send_beat(OP_UNUSED, ALL_ONES, ALL_ONES, 0);
    send_beat(OP_UNUSED, 17'h12345, '0, 0);
    send_beat(OP_UNUSED, '0, ALL_ONES, 5);
    drain_results();

    // Random blocks of 25 beats; roughly a third run back to back.
    gap_max = 14;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 25 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
      if (i == RANDOM_BEATS / 2) drain_results();
      send_beat(random_op(), random_poly(), random_poly(), $urandom_range(0, gap_max));
    end
    drain_results();
    repeat (LATENCY + 4) @(posedge clk);

    $display("Covered %0d add, %0d multiply, %0d divide (%0d by zero), %0d unused-op beats",
             book.n_by_op[OP_ADD], book.n_by_op[OP_MUL], book.n_by_op[OP_DIV],
             book.n_div_zero, book.n_by_op[OP_UNUSED]);
    $display("Checked %0d results, %0d mismatches, %0d left pending",
             book.n_checked, book.n_mismatches, book.pending());
    if (book.n_mismatches == 0 && book.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/gpa_pkg.sv
sv/gpa_cell.sv
sv/gf2_polynomial_alu.sv
sv/gpa_checker.sv
tb/tb_gf2_polynomial_alu.sv
